// ===== design/spdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// spdfa_pkg
// Shared types and constants of the speculative DFA chunk runner: operation
// codes, field widths and the command word that passes from front to back.
// ----------------------------------------------------------------------------
package spdfa_pkg;

	localparam int OP_W  = 3;
	localparam int ST_W  = 3;
	localparam int SYM_W = 4;

	localparam logic [OP_W-1:0] OP_WR_TRANS = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_ACC   = 3'd1;
	localparam logic [OP_W-1:0] OP_SYMBOL   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLOSE    = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTART  = 3'd4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ST_W-1:0]  from_state;
		logic [SYM_W-1:0] symbol;
		logic [ST_W-1:0]  to_state;
		logic             accept_bit;
	} spdfa_cmd_t;

endpackage

// ===== design/spdfa_ram.sv =====
// ----------------------------------------------------------------------------
// spdfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spdfa_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/spdfa_front.sv =====
// ----------------------------------------------------------------------------
// spdfa_front
// Accepts command transfers and drops those that have no effect: loads with
// an out-of-range index, symbols outside the alphabet and unused opcodes.
// ----------------------------------------------------------------------------
module spdfa_front
	import spdfa_pkg::*;
#(
	parameter int NUM_STATES  = 5,
	parameter int NUM_SYMBOLS = 10
) (
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  logic [OP_W-1:0]  op,
	input  logic [ST_W-1:0]  from_state,
	input  logic [SYM_W-1:0] symbol,
	input  logic [ST_W-1:0]  to_state,
	input  logic             accept_bit,
	input  logic             q_full,
	output logic             q_push,
	output spdfa_cmd_t       q_cmd
);

	logic from_ok;
	logic sym_ok;
	logic to_ok;
	logic keep;

	assign from_ok = 32'(from_state) < NUM_STATES;
	assign sym_ok  = 32'(symbol) < NUM_SYMBOLS;
	assign to_ok   = 32'(to_state) < NUM_STATES;

	always_comb begin
		keep = 1'b0;
		unique case (op) inside
			OP_WR_TRANS:          keep = from_ok && sym_ok && to_ok;
			OP_WR_ACC:            keep = from_ok;
			OP_SYMBOL:            keep = sym_ok;
			OP_CLOSE, OP_RESTART: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign cmd_ready = !q_full;
	assign q_push    = cmd_valid && !q_full && keep;
	assign q_cmd     = '{op: op, from_state: from_state, symbol: symbol,
		to_state: to_state, accept_bit: accept_bit};

endmodule

// ===== design/spdfa_queue.sv =====
// ----------------------------------------------------------------------------
// spdfa_queue
// Two-entry command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module spdfa_queue
	import spdfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  spdfa_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output spdfa_cmd_t head_cmd
);

	spdfa_cmd_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");
`endif

endmodule

// ===== design/spdfa_back.sv =====
// ----------------------------------------------------------------------------
// spdfa_back
// Executes queued commands in two stages: table access in the first, map,
// string state and accept flag update in the second, then a result register.
// ----------------------------------------------------------------------------
module spdfa_back
	import spdfa_pkg::*;
#(
	parameter int NUM_STATES  = 5,
	parameter int NUM_SYMBOLS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  spdfa_cmd_t      head_cmd,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_ready,
	output logic [ST_W-1:0] string_state,
	output logic            accepted
);

	localparam int ADDR_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

	logic                  adv1;
	logic                  adv2;
	logic                  v_s2_q;
	spdfa_cmd_t            cmd_s2;
	logic [ST_W-1:0]       row_rd [NUM_STATES];
	logic [ST_W-1:0]       map_q [NUM_STATES];
	logic [ST_W-1:0]       map_nxt [NUM_STATES];
	logic [NUM_STATES-1:0] acc_q;
	logic [ST_W-1:0]       cur_q;
	logic [ST_W-1:0]       cur_map;
	logic [ST_W-1:0]       close_state;
	logic                  close_acc;
	logic                  res_valid_q;
	logic [ST_W-1:0]       res_state_q;
	logic                  res_acc_q;

	assign adv2 = v_s2_q && (cmd_s2.op != OP_CLOSE || !res_valid_q || res_ready);
	assign adv1 = head_valid && (!v_s2_q || adv2);
	assign pop  = adv1;

	// One RAM per source state; a symbol reads the same column of all of them.
	for (genvar k = 0; k < NUM_STATES; k++) begin : g_row
		spdfa_ram #(
			.WIDTH(ST_W),
			.DEPTH(NUM_SYMBOLS)
		) u_ram (
			.clk  (clk),
			.we   (adv1 && head_cmd.op == OP_WR_TRANS &&
				head_cmd.from_state == ST_W'(k)),
			.waddr(head_cmd.symbol[ADDR_W-1:0]),
			.wdata(head_cmd.to_state),
			.re   (adv1),
			.raddr(head_cmd.symbol[ADDR_W-1:0]),
			.rdata(row_rd[k])
		);
	end

	// An index outside the state range selects state zero.
	always_comb begin
		for (int i = 0; i < NUM_STATES; i++) begin
			map_nxt[i] = row_rd[0];
			for (int j = 0; j < NUM_STATES; j++) begin
				if (map_q[i] == ST_W'(j)) begin
					map_nxt[i] = row_rd[j];
				end
			end
		end
		cur_map = map_q[0];
		for (int j = 0; j < NUM_STATES; j++) begin
			if (cur_q == ST_W'(j)) begin
				cur_map = map_q[j];
			end
		end
		close_state = '0;
		close_acc   = acc_q[0];
		for (int j = 0; j < NUM_STATES; j++) begin
			if (cur_map == ST_W'(j)) begin
				close_state = ST_W'(j);
				close_acc   = acc_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s2 <= head_cmd;
		end
		if (adv2 && cmd_s2.op == OP_CLOSE) begin
			res_state_q <= close_state;
			res_acc_q   <= close_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q      <= 1'b0;
			res_valid_q <= 1'b0;
			cur_q       <= '0;
			acc_q       <= '0;
			for (int i = 0; i < NUM_STATES; i++) begin
				map_q[i] <= ST_W'(i);
			end
		end else begin
			v_s2_q      <= adv1 || (v_s2_q && !adv2);
			res_valid_q <= (adv2 && cmd_s2.op == OP_CLOSE) || (res_valid_q && !res_ready);
			if (adv2) begin
				case (cmd_s2.op)
					OP_WR_ACC: begin
						for (int j = 0; j < NUM_STATES; j++) begin
							if (cmd_s2.from_state == ST_W'(j)) begin
								acc_q[j] <= cmd_s2.accept_bit;
							end
						end
					end
					OP_SYMBOL: begin
						for (int i = 0; i < NUM_STATES; i++) begin
							map_q[i] <= map_nxt[i];
						end
					end
					OP_CLOSE: begin
						cur_q <= close_state;
						for (int i = 0; i < NUM_STATES; i++) begin
							map_q[i] <= ST_W'(i);
						end
					end
					OP_RESTART: begin
						cur_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign string_state = res_state_q;
	assign accepted     = res_acc_q;

`ifndef SYNTHESIS
	a_close_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && cmd_s2.op == OP_CLOSE |=> res_valid_q && res_state_q == cur_q)
		else $error("close did not present the new string state");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q && !adv2 |=> v_s2_q && $stable(cmd_s2))
		else $error("stalled second stage lost its command");
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < NUM_STATES)
		else $error("string state out of range");
	a_map_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && cmd_s2.op == OP_CLOSE |=> map_q[0] == '0)
		else $error("chunk map not returned to identity");
`endif

endmodule

// ===== design/speculative_dfa_chunk_runner.sv =====
// ----------------------------------------------------------------------------
// speculative_dfa_chunk_runner
// DFA engine that follows every start state of a chunk at once and folds
// each closed chunk into the running string state.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// command   in         cmd_valid / cmd_ready   op, from_state, symbol, to_state,
//                                              accept_bit
// result    out        res_valid / res_ready   string_state, accepted
//
// One command transfer is taken per cycle while the queue is not full. A close
// passes through the command queue and then the back stage, where the table
// column read as the command left the queue feeds the map and string state
// update, and its result is presented from the result register.
// The transition table is a set of small RAMs, one per source state, so a
// symbol reads a whole table column in one access and all map entries step
// together. The table holds no defined value until written; accept flags,
// chunk map and string state are set by reset, with no clearing pass.
// A stalled result stalls only closes in the back stage; the queue keeps
// taking commands until it is full.
//
module speculative_dfa_chunk_runner
	import spdfa_pkg::*;
#(
	parameter int NUM_STATES  = 5,
	parameter int NUM_SYMBOLS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  logic [OP_W-1:0]  op,
	input  logic [ST_W-1:0]  from_state,
	input  logic [SYM_W-1:0] symbol,
	input  logic [ST_W-1:0]  to_state,
	input  logic             accept_bit,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [ST_W-1:0]  string_state,
	output logic             accepted
);

	// Front to queue: commands that survive the range checks.
	logic       q_full;
	logic       q_push;
	spdfa_cmd_t q_cmd;

	// Queue to back.
	logic       head_valid;
	spdfa_cmd_t head_cmd;
	logic       q_pop;

	spdfa_front #(
		.NUM_STATES (NUM_STATES),
		.NUM_SYMBOLS(NUM_SYMBOLS)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.op        (op),
		.from_state(from_state),
		.symbol    (symbol),
		.to_state  (to_state),
		.accept_bit(accept_bit),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	// The queue lets the front keep accepting while a close waits on output.
	spdfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	// The back end owns the table, the chunk map and the string state.
	spdfa_back #(
		.NUM_STATES (NUM_STATES),
		.NUM_SYMBOLS(NUM_SYMBOLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (q_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.string_state(string_state),
		.accepted    (accepted)
	);

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb - testbench of speculative_dfa_chunk_runner
// Drives table loads, accept flag loads, symbols, chunk closes, restarts and
// spare opcodes through the command channel. A local model of the automaton
// predicts every chunk result, and the result channel is checked against it
// in order. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
	import spdfa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Block configuration; the model below follows the same sizes.
	localparam int N_ST = 5;
	localparam int N_SY = 10;

	// Opcodes that the block treats as no-ops.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_CMDS  = 1530;
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 10;

	// One queued command plus a flag that holds it back until every
	// outstanding chunk result has been received.
	typedef struct packed {
		spdfa_cmd_t cmd;
		bit         drain;
	} queued_cmd_t;

	typedef struct packed {
		logic [ST_W-1:0] state;
		logic            acc;
	} chunk_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_ready;
	logic [OP_W-1:0]  op = OP_WR_TRANS;
	logic [ST_W-1:0]  from_state = '0;
	logic [SYM_W-1:0] symbol = '0;
	logic [ST_W-1:0]  to_state = '0;
	logic             accept_bit = 1'b0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	logic [ST_W-1:0]  string_state;
	logic             accepted;

	speculative_dfa_chunk_runner #(
		.NUM_STATES (N_ST),
		.NUM_SYMBOLS(N_SY)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.op          (op),
		.from_state  (from_state),
		.symbol      (symbol),
		.to_state    (to_state),
		.accept_bit  (accept_bit),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.string_state(string_state),
		.accepted    (accepted)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Automaton model. The transition table is only ever read where it
	// has been written, because the stimulus never issues a symbol whose
	// column is incomplete.
	// ------------------------------------------------------------------
	logic [ST_W-1:0] trans_mem [8][16];
	bit              accept_mem [8];
	logic [ST_W-1:0] span_map [8];
	logic [ST_W-1:0] run_state;

	chunk_result_t due_chunk_results[$];
	queued_cmd_t   cmd_backlog[$];

	// Which table entries the stimulus has loaded so far.
	bit loaded [8][16];

	int n_loads, n_steps, n_closes, n_restarts, n_checked, n_errors;
	int cmds_sent, cmds_total;
	int unsigned cyc_count;
	int send_gap, recv_gap;
	queued_cmd_t cmd_live;

	initial begin
		for (int s = 0; s < 8; s++) begin
			accept_mem[s] = 1'b0;
			span_map[s] = ST_W'(s);
			for (int y = 0; y < 16; y++) begin
				trans_mem[s][y] = '0;
				loaded[s][y] = 1'b0;
			end
		end
		run_state = '0;
	end

	// Apply one accepted command to the model and record any chunk result
	// that it causes.
	task automatic dfa_step(input spdfa_cmd_t c);
		case (c.op)
			OP_WR_TRANS: begin
				if (c.from_state < N_ST && c.symbol < N_SY && c.to_state < N_ST) begin
					trans_mem[c.from_state][c.symbol] = c.to_state;
					n_loads++;
				end
			end
			OP_WR_ACC: begin
				if (c.from_state < N_ST)
					accept_mem[c.from_state] = c.accept_bit;
			end
			OP_SYMBOL: begin
				// Every start state steps through the same table column.
				if (c.symbol < N_SY) begin
					for (int s = 0; s < N_ST; s++)
						span_map[s] = trans_mem[span_map[s]][c.symbol];
					n_steps++;
				end
			end
			OP_CLOSE: begin
				// Fold the chunk into the string, then start a fresh chunk.
				run_state = span_map[run_state];
				for (int s = 0; s < 8; s++)
					span_map[s] = ST_W'(s);
				due_chunk_results.push_back('{state: run_state,
					acc: accept_mem[run_state]});
				n_closes++;
			end
			OP_RESTART: begin
				run_state = '0;
				n_restarts++;
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stimulus building.
	// ------------------------------------------------------------------
	task automatic queue_cmd(input logic [OP_W-1:0] o, input int f, input int y,
			input int t, input int a, input bit drain);
		queued_cmd_t q;
		q.cmd.op = o;
		q.cmd.from_state = ST_W'(f);
		q.cmd.symbol = SYM_W'(y);
		q.cmd.to_state = ST_W'(t);
		q.cmd.accept_bit = a[0];
		q.drain = drain;
		if (o == OP_WR_TRANS && f < N_ST && y < N_SY && t < N_ST)
			loaded[f][y] = 1'b1;
		cmd_backlog.push_back(q);
	endtask

	function automatic bit column_ready(input int y);
		for (int s = 0; s < N_ST; s++)
			if (!loaded[s][y])
				return 1'b0;
		return 1'b1;
	endfunction

	// Random commands are mostly well-formed: table and accept flag loads,
	// symbols over complete columns and closes, with some out-of-range loads,
	// ignored symbols, restarts and spare opcodes mixed in. A symbol whose
	// column is not yet complete turns into a load of a missing entry, so the
	// early part of the run fills the table.
	task automatic queue_random(input int count);
		int r, f, y, t, a, s;
		bit drain;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			f = $urandom_range(0, 7);
			y = $urandom_range(0, 15);
			t = $urandom_range(0, 7);
			a = $urandom_range(0, 1);
			drain = (k == 400 || k == 900);
			if (r < 22) begin
				f = $urandom_range(0, N_ST - 1);
				y = $urandom_range(0, N_SY - 1);
				t = $urandom_range(0, N_ST - 1);
				case ($urandom_range(0, 23))
					0: f = $urandom_range(N_ST, 7);
					1: y = $urandom_range(N_SY, 15);
					2: t = $urandom_range(N_ST, 7);
					default: begin
					end
				endcase
				queue_cmd(OP_WR_TRANS, f, y, t, a, drain);
			end else if (r < 30) begin
				queue_cmd(OP_WR_ACC, f, y, t, a, drain);
			end else if (r < 75) begin
				y = $urandom_range(0, N_SY - 1);
				if (column_ready(y)) begin
					queue_cmd(OP_SYMBOL, f, y, t, a, drain);
				end else begin
					s = 0;
					while (loaded[s][y])
						s++;
					queue_cmd(OP_WR_TRANS, s, y, $urandom_range(0, N_ST - 1), a, drain);
				end
			end else if (r < 78) begin
				queue_cmd(OP_SYMBOL, f, $urandom_range(N_SY, 15), t, a, drain);
			end else if (r < 90) begin
				queue_cmd(OP_CLOSE, f, y, t, a, drain);
			end else if (r < 95) begin
				queue_cmd(OP_RESTART, f, y, t, a, drain);
			end else begin
				queue_cmd(OP_SPARE_LO + OP_W'($urandom_range(0, 2)), f, y, t, a, drain);
			end
		end
	endtask

	// Sender and receiver may idle except in every third block of 128
	// commands and in the final stretch of the run.
	function automatic bit may_idle();
		return (cmds_sent + QUIET_TAIL < cmds_total) && ((cmds_sent / 128) % 3 != 2);
	endfunction

	// ------------------------------------------------------------------
	// Command driver. A new command is presented only when the channel is
	// empty or its current command transfers at this edge, so the payload
	// holds steady while valid waits for ready.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			op <= OP_WR_TRANS;
			from_state <= '0;
			symbol <= '0;
			to_state <= '0;
			accept_bit <= 1'b0;
			send_gap = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				dfa_step(cmd_live.cmd);
				cmds_sent++;
				if (may_idle() && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 9);
			end
			if (!cmd_valid || cmd_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0 &&
						!(cmd_backlog[0].drain && due_chunk_results.size() != 0)) begin
					cmd_live = cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
					op <= cmd_live.cmd.op;
					from_state <= cmd_live.cmd.from_state;
					symbol <= cmd_live.cmd.symbol;
					to_state <= cmd_live.cmd.to_state;
					accept_bit <= cmd_live.cmd.accept_bit;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor. Every result transfer is matched against the oldest
	// predicted chunk result. Ready drops in random bursts.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : res_monitor
		chunk_result_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (due_chunk_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual state %0d accepted %0d",
						$time, string_state, accepted);
					n_errors++;
				end else begin
					want = due_chunk_results.pop_front();
					if (string_state !== want.state) begin
						$display("%0t: string_state mismatch, expected %0d, actual %0d",
							$time, want.state, string_state);
						n_errors++;
					end
					if (accepted !== want.acc) begin
						$display("%0t: accepted mismatch, expected %0d, actual %0d",
							$time, want.acc, accepted);
						n_errors++;
					end
					n_checked++;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				res_ready <= 1'b0;
			end else if (may_idle() && $urandom_range(0, 6) == 0) begin
				recv_gap = $urandom_range(0, 8);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d of %0d commands sent, %0d results due",
				$time, cyc_count, cmds_sent, cmds_total, due_chunk_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		// Directed part. A close straight after reset sees the identity map
		// and the cleared accept flags.
		queue_cmd(OP_CLOSE, 0, 0, 0, 0, 1'b0);
		// Accept flag load of a state past the last one is dropped.
		queue_cmd(OP_WR_ACC, 7, 15, 7, 1, 1'b0);
		queue_cmd(OP_WR_ACC, 0, 0, 0, 1, 1'b0);
		queue_cmd(OP_WR_ACC, N_ST - 1, 0, 0, 0, 1'b0);
		queue_cmd(OP_CLOSE, 0, 0, 0, 0, 1'b0);
		// Column 0 rotates every state by one.
		for (int s = 0; s < N_ST; s++)
			queue_cmd(OP_WR_TRANS, s, 0, (s + 1) % N_ST, 0, 1'b0);
		// Loads with a state, symbol or target out of range are dropped.
		queue_cmd(OP_WR_TRANS, 7, 0, 1, 1, 1'b0);
		queue_cmd(OP_WR_TRANS, 0, 15, 2, 0, 1'b0);
		queue_cmd(OP_WR_TRANS, 0, 0, 7, 0, 1'b0);
		queue_cmd(OP_SYMBOL, 0, 0, 0, 0, 1'b0);
		// A symbol past the alphabet leaves the map alone.
		queue_cmd(OP_SYMBOL, 7, 15, 7, 1, 1'b0);
		// Spare opcodes do nothing, whatever their fields hold.
		queue_cmd(OP_SPARE_LO, 7, 15, 7, 1, 1'b0);
		queue_cmd(OP_SPARE_LO + 3'd1, 0, 9, 0, 0, 1'b0);
		queue_cmd(OP_SPARE_HI, 4, 0, 4, 1, 1'b0);
		queue_cmd(OP_CLOSE, 0, 0, 0, 0, 1'b0);
		// Restart brings the string back to state 0 but keeps the map.
		queue_cmd(OP_SYMBOL, 0, 0, 0, 0, 1'b0);
		queue_cmd(OP_RESTART, 3, 3, 3, 0, 1'b0);
		queue_cmd(OP_CLOSE, 0, 0, 0, 0, 1'b0);
		queue_cmd(OP_CLOSE, 0, 0, 0, 0, 1'b0);
		// The random part starts only once the directed results are in.
		queue_cmd(OP_RESTART, 0, 0, 0, 0, 1'b1);
		queue_random(RANDOM_CMDS);
		cmds_total = cmd_backlog.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || cmd_valid)
			@(posedge clk);
		while (due_chunk_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d table loads, %0d symbol steps, %0d restarts.",
			cmds_sent, n_loads, n_steps, n_restarts);
		$display("Checked %0d of %0d chunk results, %0d mismatches.",
			n_checked, n_closes, n_errors);
		if (n_errors == 0 && due_chunk_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
